[rtl/asp_pkg.sv]
// Shared constants, types and helpers of the auto-scaling sample packer.
package asp_pkg;

  localparam int BLOCK_WORDS   = 256;
  localparam int ADDR_W        = $clog2(BLOCK_WORDS);
  localparam int MAX_INTERVALS = 32;
  localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
  localparam int CHANNELS      = 8;

  localparam int WORD_W   = 16;
  localparam int IVL_W    = 6;
  localparam int CH_W     = 3;
  localparam int QS_W     = 5;
  localparam int SAMPLE_W = 32;
  localparam int SCALE_W  = 2;
  localparam int WADDR_W  = 8;

  localparam logic [SAMPLE_W-1:0] SAMPLE_LIMIT    = 32'd524287;
  localparam logic [WORD_W-1:0]   WORD_INVALID    = 16'hFFFF;
  localparam logic [WORD_W-1:0]   WORD_SATURATED  = 16'hFFFE;
  localparam logic [ADDR_W-1:0]   SCALE_ADDR      = ADDR_W'(3);
  localparam logic [ADDR_W-1:0]   STREAM_BASE     = ADDR_W'(3);
  localparam logic [IVL_W-1:0]    INTERVALS_RESET = 6'd24;

  // Configuration port: byte address 4*i for register i
  localparam int PADDR_W  = 3;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_INTERVALS = '0;

  typedef enum logic [1:0] {
    ACT_STORE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RS_RD,
    ST_RS_WR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic rs_rd;
    logic rs_wr;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    action_t action;
    logic    need_loop;
    logic    last_word;
  } dp_status_t;

  function automatic logic [SCALE_W-1:0] scale_of(input logic [WORD_W-1:0] w,
                                                  input logic [CH_W-1:0] ch);
    logic [SCALE_W-1:0] s;
    s = w[{ch, 1'b0} +: SCALE_W];
    if (int'(ch) >= CHANNELS) begin
      s = '0;
    end
    return s;
  endfunction

endpackage

[rtl/asp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module asp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/asp_ctrl.sv]
// Sequencer of the packer: steps each command and the rescale walk.
module asp_ctrl
  import asp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (status.action == ACT_STORE && status.need_loop) begin
          state_next = ST_RS_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RS_RD: begin
        cmd.rs_rd  = 1'b1;
        state_next = ST_RS_WR;
      end
      ST_RS_WR: begin
        cmd.rs_wr = 1'b1;
        if (status.last_word) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_RS_RD;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/asp_dp.sv]
// Datapath of the packer: word store, valid bits, scale word, result register.
module asp_dp
  import asp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_status_t          status,
  input  logic [IVL_W-1:0]    block_intervals,
  input  logic [1:0]          action,
  input  logic [IVL_W-1:0]    interval,
  input  logic [CH_W-1:0]     channel,
  input  logic [QS_W-1:0]     quarter_stream,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [WADDR_W-1:0]  word_address,
  output logic                done,
  output logic [WORD_W-1:0]   stored_value,
  output logic [SCALE_W-1:0]  channel_scale,
  output logic                rescaled,
  output logic                data_error
);

  // Latched command
  action_t             act_r;
  logic [IVL_W-1:0]    ivl_r;
  logic [CH_W-1:0]     ch_r;
  logic [QS_W-1:0]     qs_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [ADDR_W-1:0]   raddr_r;

  // Rescale walk
  logic [ADDR_W-1:0]  start_r;
  logic [SCALE_W-1:0] tgt_r;
  logic [SCALE_W-1:0] inc_r;
  logic               resc_r;
  logic [IVL_W-1:0]   idx_r;

  logic [WORD_W-1:0]      scale_word;
  logic [WORD_W-1:0]      scale_word_next;
  logic [BLOCK_WORDS-1:0] valid;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [CNT_W-1:0]   count;
  logic [SCALE_W-1:0] cur;
  logic [SCALE_W-1:0] need;
  logic [SCALE_W-1:0] tgt_c;
  logic [SCALE_W-1:0] inc_c;
  logic               resc_c;
  logic               err_c;
  logic [15:0]        start_full;
  logic [ADDR_W-1:0]  start_c;
  logic               need_loop;

  logic [ADDR_W-1:0]   l_addr;
  logic [ADDR_W-1:0]   view_addr;
  logic [WORD_W-1:0]   view_word;
  logic [WORD_W-1:0]   shifted_word;

  logic                f_go;
  logic [ADDR_W-1:0]   f_start;
  logic [SCALE_W-1:0]  f_tgt;
  logic [SCALE_W-1:0]  f_inc;
  logic                f_resc;
  logic [ADDR_W-1:0]   f_addr;
  logic [SAMPLE_W-1:0] f_shift;
  logic [WORD_W-1:0]   f_value;
  logic [WORD_W-1:0]   scale_upd;

  logic                clr;
  logic                emit;
  logic [WORD_W-1:0]   value_next;

  asp_ram #(
    .WIDTH(WORD_W),
    .DEPTH(BLOCK_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r    <= action_t'(action);
      ivl_r    <= interval;
      ch_r     <= channel;
      qs_r     <= quarter_stream;
      sample_r <= sample;
      raddr_r  <= ADDR_W'(word_address);
    end
    if (cmd.exec) begin
      start_r <= start_c;
      tgt_r   <= tgt_c;
      inc_r   <= inc_c;
      resc_r  <= resc_c;
      idx_r   <= IVL_W'(1);
    end else if (cmd.rs_wr) begin
      idx_r <= idx_r + IVL_W'(1);
    end
  end

  // Store checks and scale target, from the latched command
  always_comb begin
    if (int'(block_intervals) > MAX_INTERVALS) begin
      count = CNT_W'(MAX_INTERVALS);
    end else begin
      count = CNT_W'(block_intervals);
    end
    cur   = scale_of(scale_word, ch_r);
    err_c = (int'(ch_r) >= CHANNELS) || (ivl_r == '0) ||
            (CNT_W'(ivl_r) > count) || (sample_r >= SAMPLE_LIMIT);
    if (sample_r[SAMPLE_W-1:18] != '0) begin
      need = 2'd3;
    end else if (sample_r[17]) begin
      need = 2'd2;
    end else if (sample_r[16]) begin
      need = 2'd1;
    end else begin
      need = 2'd0;
    end
    tgt_c      = (need > cur) ? need : cur;
    inc_c      = tgt_c - cur;
    resc_c     = (tgt_c != cur);
    start_full = 16'(STREAM_BASE) + 16'(qs_r[QS_W-1:2]) * 16'(count);
    start_c    = start_full[ADDR_W-1:0];
    need_loop  = (act_r == ACT_STORE) && !err_c && resc_c && (ivl_r > IVL_W'(1));
  end

  assign status.action    = act_r;
  assign status.need_loop = need_loop;
  assign status.last_word = (idx_r == ivl_r - IVL_W'(1));

  // Word whose registered read data is now on the RAM output
  assign l_addr    = start_r + ADDR_W'(idx_r);
  assign view_addr = cmd.rs_wr ? l_addr : raddr_r;
  always_comb begin
    if (view_addr == SCALE_ADDR) begin
      view_word = scale_word;
    end else if (!valid[view_addr]) begin
      view_word = WORD_INVALID;
    end else begin
      view_word = ram_rdata;
    end
  end
  assign shifted_word = view_word >> inc_r;

  assign ram_raddr = cmd.rs_rd ? l_addr : ADDR_W'(word_address);

  // Final store: live values when no walk was needed, held ones after it
  assign f_go    = cmd.finish ||
                   (cmd.exec && act_r == ACT_STORE && !err_c && !need_loop);
  assign f_start = cmd.exec ? start_c : start_r;
  assign f_tgt   = cmd.exec ? tgt_c : tgt_r;
  assign f_inc   = cmd.exec ? inc_c : inc_r;
  assign f_resc  = cmd.exec ? resc_c : resc_r;
  assign f_addr  = f_start + ADDR_W'(ivl_r);
  assign f_shift = sample_r >> f_tgt;
  always_comb begin
    f_value = f_shift[WORD_W-1:0];
    if (f_value == WORD_INVALID) begin
      f_value = WORD_SATURATED;
    end
  end
  assign scale_upd = scale_word + (WORD_W'(f_inc) << {ch_r, 1'b0});

  assign clr = cmd.exec && act_r == ACT_CLEAR;

  // One write per cycle: rescaled word, final word, or nothing
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = f_addr;
    ram_wdata       = f_value;
    scale_word_next = scale_word;
    if (cmd.rs_wr) begin
      ram_waddr = l_addr;
      ram_wdata = shifted_word;
      if (view_word != WORD_INVALID) begin
        if (l_addr == SCALE_ADDR) begin
          scale_word_next = shifted_word;
        end else begin
          ram_we = 1'b1;
        end
      end
    end else if (f_go) begin
      if (f_addr == SCALE_ADDR) begin
        scale_word_next = f_value;
      end else begin
        ram_we          = 1'b1;
        scale_word_next = scale_upd;
      end
    end else if (clr) begin
      scale_word_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_word <= '0;
      valid      <= '0;
    end else begin
      scale_word <= scale_word_next;
      if (clr) begin
        valid <= '0;
      end else if (ram_we) begin
        valid[ram_waddr] <= 1'b1;
      end
    end
  end

  // Result register
  assign emit = cmd.finish || (cmd.exec && !need_loop);
  always_comb begin
    value_next = '0;
    if (f_go) begin
      value_next = f_value;
    end else if (act_r == ACT_READ) begin
      value_next = view_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= emit;
    end
    if (emit) begin
      stored_value  <= value_next;
      channel_scale <= scale_of(scale_word_next, ch_r);
      rescaled      <= f_go && f_resc;
      data_error    <= (act_r == ACT_STORE) && err_c;
    end
  end

endmodule

[rtl/autoscaling_sample_packer_top.sv]
// Top level of the auto-scaling sample packer: configuration register and core.
//
// Usage:
//   Command channel: drive action, interval, channel, quarter_stream, sample
//   and word_address with start high; the command transfers at the clock edge
//   where start is high and busy is low. Each command yields one result,
//   shown on stored_value, channel_scale, rescaled and data_error for exactly
//   one cycle while done is high. The receiver takes every result; there is
//   no back-pressure on the result side.
//   Read, clear, no-op, rejected store and a store without a rescale walk
//   pass from transfer through the exec state to the done cycle, and busy is
//   already low in the done cycle, so the next command can transfer at the
//   edge that ends it. A store that raises the scale at interval N walks the
//   N-1 earlier words of its stream through the single word RAM (a read state
//   and a write state per word), then a finish state writes the new word.
//   Configuration: APB-style port, block_intervals at byte address 0;
//   write it only while the block is idle. pready is tied high.
//   Reset: synchronous, active high. Clears the sequencer, the per-word
//   valid bits (all but the scale word read as the invalid mark) and the
//   scale word, and loads block_intervals with 24. No clearing pass is needed.
module autoscaling_sample_packer_top
  import asp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // command channel
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          action,
  input  logic [IVL_W-1:0]    interval,
  input  logic [CH_W-1:0]     channel,
  input  logic [QS_W-1:0]     quarter_stream,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [WADDR_W-1:0]  word_address,
  // result channel
  output logic                done,
  output logic [WORD_W-1:0]   stored_value,
  output logic [SCALE_W-1:0]  channel_scale,
  output logic                rescaled,
  output logic                data_error,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [IVL_W-1:0] block_intervals;
  logic             cfg_hit;
  dp_cmd_t          cmd;
  dp_status_t       status;

  // Register decode: the word index sits above the byte offset
  assign cfg_hit = (paddr[PADDR_W-1:2] == REG_BLOCK_INTERVALS);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_intervals <= INTERVALS_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      block_intervals <= pwdata[IVL_W-1:0];
    end
  end

  // Return the register on a hit, zero elsewhere
  always_comb begin
    prdata = '0;
    if (cfg_hit) begin
      prdata = 32'(block_intervals);
    end
  end

  asp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .status(status),
    .cmd   (cmd)
  );

  asp_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .block_intervals(block_intervals),
    .action         (action),
    .interval       (interval),
    .channel        (channel),
    .quarter_stream (quarter_stream),
    .sample         (sample),
    .word_address   (word_address),
    .done           (done),
    .stored_value   (stored_value),
    .channel_scale  (channel_scale),
    .rescaled       (rescaled),
    .data_error     (data_error)
  );

endmodule

[tb/sv/autoscaling_sample_packer_top_tb.sv]
// Self-checking testbench for the auto-scaling sample packer: predictor, scoreboard and drivers.
module autoscaling_sample_packer_top_tb
  import asp_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with neither a command transfer nor a result before the run is declared hung.
  // The slowest command walks 31 words; gaps and config writes stay well below.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 500;

  typedef struct packed {
    logic [WORD_W-1:0]  value;
    logic [SCALE_W-1:0] scale;
    logic               rescaled;
    logic               err;
  } packer_outcome_t;

  // Scoreboard: mirrors the block memory and scale word, predicts one outcome per
  // accepted command and checks results in order.
  class packer_scoreboard;
    logic [WORD_W-1:0] words_mirror [BLOCK_WORDS];
    logic [WORD_W-1:0] scale_mirror;
    int unsigned       intervals_cfg;
    packer_outcome_t   outcomes_due[$];
    int unsigned       errors;

    function new();
      foreach (words_mirror[i]) words_mirror[i] = WORD_INVALID;
      scale_mirror  = '0;
      intervals_cfg = 24;
      errors        = 0;
    endfunction

    function void load_intervals(int unsigned v);
      intervals_cfg = v & 32'h3F;
    endfunction

    function int unsigned outstanding();
      return outcomes_due.size();
    endfunction

    // Address 3 aliases the scale word; everything wraps at the block size.
    function logic [WORD_W-1:0] word_at(int unsigned addr);
      int unsigned a;
      a = addr % BLOCK_WORDS;
      if (a == 3) return scale_mirror;
      return words_mirror[a];
    endfunction

    function void put_word(int unsigned addr, logic [WORD_W-1:0] w);
      int unsigned a;
      a = addr % BLOCK_WORDS;
      if (a == 3) scale_mirror = w;
      else words_mirror[a] = w;
    endfunction

    function int unsigned chan_scale(logic [CH_W-1:0] ch);
      if (int'(ch) >= CHANNELS) return 0;
      return (scale_mirror >> (2 * ch)) & 3;
    endfunction

    // Advance the mirror by one command and queue the outcome it must produce.
    function void apply_command(action_t act, logic [IVL_W-1:0] ivl, logic [CH_W-1:0] ch,
                                logic [QS_W-1:0] qs, logic [SAMPLE_W-1:0] smp,
                                logic [WADDR_W-1:0] waddr);
      packer_outcome_t r;
      int unsigned cnt, base, cur, tgt, inc, val, i;
      logic [WORD_W-1:0] w;
      r   = '0;
      cnt = (intervals_cfg > MAX_INTERVALS) ? MAX_INTERVALS : intervals_cfg;
      case (act)
        ACT_STORE: begin
          if (int'(ch) >= CHANNELS || ivl == 0 || ivl > cnt || smp >= SAMPLE_LIMIT) begin
            r.err = 1'b1;
          end else begin
            base = 3 + (qs / 4) * cnt;
            cur  = chan_scale(ch);
            tgt  = cur;
            while (tgt < 3 && (smp >> (16 + tgt)) != 0) tgt++;
            if (tgt != cur) begin
              // shift earlier intervals down, leaving never-written words alone
              inc = tgt - cur;
              for (i = 1; i < ivl; i++) begin
                w = word_at(base + i);
                if (w != WORD_INVALID) put_word(base + i, w >> inc);
              end
              scale_mirror = scale_mirror + WORD_W'(inc << (2 * ch));
              r.rescaled   = 1'b1;
            end
            val = smp >> tgt;
            if (val == 65535) val = 65534;
            put_word(base + ivl, WORD_W'(val));
            r.value = WORD_W'(val);
          end
        end
        ACT_READ: r.value = word_at(32'(waddr));
        ACT_CLEAR: begin
          foreach (words_mirror[i]) words_mirror[i] = WORD_INVALID;
          scale_mirror = '0;
        end
        default: ;
      endcase
      r.scale = SCALE_W'(chan_scale(ch));
      outcomes_due.push_back(r);
    endfunction

    // Fields print as value/scale/rescaled/error.
    function void check_outcome(packer_outcome_t got);
      packer_outcome_t want;
      if (outcomes_due.size() == 0) begin
        $display("%0t: unexpected result: value=%h scale=%0d rescaled=%0b error=%0b",
                 $time, got.value, got.scale, got.rescaled, got.err);
        errors++;
        return;
      end
      want = outcomes_due.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch: expected %h/%0d/%0b/%0b actual %h/%0d/%0b/%0b",
                 $time, want.value, want.scale, want.rescaled, want.err,
                 got.value, got.scale, got.rescaled, got.err);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [1:0]          action;
  logic [IVL_W-1:0]    interval;
  logic [CH_W-1:0]     channel;
  logic [QS_W-1:0]     quarter_stream;
  logic [SAMPLE_W-1:0] sample;
  logic [WADDR_W-1:0]  word_address;
  logic                done;
  logic [WORD_W-1:0]   stored_value;
  logic [SCALE_W-1:0]  channel_scale;
  logic                rescaled;
  logic                data_error;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  packer_scoreboard sb = new();

  bit          gaps_on = 1'b1;   // random idle cycles on the command side
  int unsigned fed;              // commands transferred in the current part
  int unsigned eff_intervals = 24;
  int unsigned stall_cycles = 0;

  autoscaling_sample_packer_top uut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .action(action), .interval(interval), .channel(channel),
    .quarter_stream(quarter_stream), .sample(sample), .word_address(word_address),
    .done(done), .stored_value(stored_value), .channel_scale(channel_scale),
    .rescaled(rescaled), .data_error(data_error),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Both monitors sample at the edge: check the finishing result first, then
  // predict the command that transfers on the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_outcome({stored_value, channel_scale, rescaled, data_error});
      if (start && !busy) begin
        sb.apply_command(action_t'(action), interval, channel, quarter_stream, sample,
                         word_address);
      end
    end
  end

  // Watchdog: any transfer or result restarts the count.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one command and hold it until the transfer edge. Optionally drop
  // start for a few cycles first so gaps land on every phase of the block.
  task automatic issue(action_t a, logic [IVL_W-1:0] ivl, logic [CH_W-1:0] ch,
                       logic [QS_W-1:0] qs, logic [SAMPLE_W-1:0] smp,
                       logic [WADDR_W-1:0] waddr);
    int unsigned gap;
    if (gaps_on && $urandom_range(99) < 29) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    action         <= a;
    interval       <= ivl;
    channel        <= ch;
    quarter_stream <= qs;
    sample         <= smp;
    word_address   <= waddr;
    @(posedge clk);
    while (busy) @(posedge clk);
    fed++;
  endtask

  // Command with every field random but the action.
  task automatic issue_any(action_t a);
    issue(a, IVL_W'($urandom), CH_W'($urandom), QS_W'($urandom), $urandom,
          WADDR_W'($urandom));
  endtask

  // Drop start, let the monitor see the last transfer, then drain every result
  // and give the block a few cycles to settle.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write of block_intervals: setup cycle, access cycle, release.
  task automatic set_intervals(int unsigned v);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_BLOCK_INTERVALS, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.load_intervals(v);
    eff_intervals = (v > MAX_INTERVALS) ? MAX_INTERVALS : v;
  endtask

  // Samples by needed scale: band 0 fits unscaled, band 3 needs a shift of 3,
  // band 4 is out of range. Band edges come up often.
  function automatic logic [SAMPLE_W-1:0] pick_sample(int unsigned band);
    logic [SAMPLE_W-1:0] lo, hi;
    case (band)
      0: begin lo = 32'd0;      hi = 32'd65535;  end
      1: begin lo = 32'd65536;  hi = 32'd131071; end
      2: begin lo = 32'd131072; hi = 32'd262143; end
      3: begin lo = 32'd262144; hi = 32'd524286; end
      default: begin lo = SAMPLE_LIMIT; hi = 32'hFFFF_FFFF; end
    endcase
    case ($urandom_range(9))
      0: return lo;
      1: return hi;
      2: return hi - 1;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // Noise between well-formed stores: reads, rejects, no-ops, stray stores, clears.
  task automatic stir();
    int unsigned r;
    logic [IVL_W-1:0] bad_ivl;
    logic [IVL_W-1:0] good_ivl;
    r = $urandom_range(99);
    bad_ivl = ($urandom_range(1) == 0 || eff_intervals >= 63) ? IVL_W'(0)
              : IVL_W'($urandom_range(eff_intervals + 1, 63));
    good_ivl = (eff_intervals == 0) ? IVL_W'(1)
               : IVL_W'($urandom_range(1, eff_intervals));
    if (r < 30) begin
      issue(ACT_READ, IVL_W'($urandom), CH_W'($urandom), QS_W'($urandom), $urandom,
            WADDR_W'($urandom_range(0, 255)));
    end else if (r < 50) begin
      issue_any(ACT_STORE);
    end else if (r < 65) begin
      issue(ACT_STORE, bad_ivl, CH_W'($urandom), QS_W'($urandom),
            pick_sample($urandom_range(0, 3)), WADDR_W'($urandom));
    end else if (r < 80) begin
      issue_any(ACT_NOP);
    end else if (r < 95) begin
      issue(ACT_STORE, good_ivl, CH_W'($urandom), QS_W'($urandom),
            pick_sample($urandom_range(0, 4)), WADDR_W'($urandom));
    end else begin
      issue_any(ACT_CLEAR);
    end
  endtask

  // Fill one stream in interval order with samples that tend to grow, so the
  // channel scale climbs and earlier words get walked; then read some back.
  task automatic run_stream();
    logic [QS_W-1:0] qs;
    logic [CH_W-1:0] ch;
    int unsigned last, band, iv, base;
    qs   = QS_W'($urandom_range(0, 31));
    ch   = CH_W'($urandom_range(0, 7));
    last = (eff_intervals == 0) ? 3 : $urandom_range(1, eff_intervals);
    band = 0;
    for (iv = 1; iv <= last; iv++) begin
      if ($urandom_range(99) < 15) stir();
      if (band < 3 && $urandom_range(99) < 25) band++;
      issue(ACT_STORE, IVL_W'(iv), ch, qs, pick_sample($urandom_range(0, band)),
            WADDR_W'($urandom));
    end
    base = 3 + (qs / 4) * eff_intervals;
    repeat ($urandom_range(1, 4)) begin
      issue(ACT_READ, IVL_W'($urandom), ch, qs, $urandom,
            WADDR_W'(base + $urandom_range(1, last)));
    end
    if ($urandom_range(1) == 0) issue(ACT_READ, IVL_W'($urandom), ch, qs, $urandom, WADDR_W'(3));
  endtask

  initial begin
    int unsigned phase, setting;
    rst            <= 1'b1;
    start          <= 1'b0;
    action         <= ACT_NOP;
    interval       <= '0;
    channel        <= '0;
    quarter_stream <= '0;
    sample         <= '0;
    word_address   <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset contents, scale climb with a walk that skips an empty
    // word, saturation to 0xFFFE, every reject, no-op, clear.
    issue(ACT_READ,  6'd0,  3'd0, 5'd0,  32'd0,          8'd3);
    issue(ACT_READ,  6'd0,  3'd0, 5'd0,  32'd0,          8'd4);
    issue(ACT_READ,  6'd0,  3'd0, 5'd0,  32'd0,          8'd255);
    issue(ACT_STORE, 6'd1,  3'd0, 5'd0,  32'd0,          8'd0);
    issue(ACT_STORE, 6'd2,  3'd0, 5'd0,  32'd65535,      8'd0);
    issue(ACT_STORE, 6'd3,  3'd0, 5'd0,  32'd65536,      8'd0);
    issue(ACT_STORE, 6'd5,  3'd0, 5'd0,  32'd524286,     8'd0);
    issue(ACT_READ,  6'd0,  3'd0, 5'd0,  32'd0,          8'd5);
    issue(ACT_READ,  6'd0,  3'd0, 5'd0,  32'd0,          8'd6);
    issue(ACT_READ,  6'd0,  3'd0, 5'd0,  32'd0,          8'd7);
    issue(ACT_READ,  6'd0,  3'd0, 5'd0,  32'd0,          8'd3);
    issue(ACT_STORE, 6'd0,  3'd1, 5'd0,  32'd1,          8'd0);
    issue(ACT_STORE, 6'd25, 3'd1, 5'd0,  32'd1,          8'd0);
    issue(ACT_STORE, 6'd63, 3'd1, 5'd0,  32'd1,          8'd0);
    issue(ACT_STORE, 6'd4,  3'd1, 5'd0,  SAMPLE_LIMIT,   8'd0);
    issue(ACT_STORE, 6'd4,  3'd1, 5'd0,  32'hFFFF_FFFF,  8'd0);
    issue(ACT_NOP,   6'd63, 3'd0, 5'd31, 32'hFFFF_FFFF,  8'd255);
    issue(ACT_STORE, 6'd24, 3'd7, 5'd31, 32'd131071,     8'd0);
    issue(ACT_READ,  6'd0,  3'd7, 5'd0,  32'd0,          8'd195);
    issue(ACT_CLEAR, 6'd0,  3'd0, 5'd0,  32'd0,          8'd0);
    issue(ACT_READ,  6'd0,  3'd7, 5'd0,  32'd0,          8'd5);
    // Largest count: the last slot of the last stream wraps onto the scale word.
    set_intervals(32);
    issue(ACT_STORE, 6'd32, 3'd1, 5'd31, 32'd5,          8'd0);
    issue(ACT_READ,  6'd0,  3'd1, 5'd0,  32'd0,          8'd3);
    // Zero count rejects every store; counts past the maximum act as the maximum.
    set_intervals(0);
    issue(ACT_STORE, 6'd1,  3'd2, 5'd0,  32'd1,          8'd0);
    set_intervals(63);
    issue(ACT_STORE, 6'd32, 3'd3, 5'd4,  32'd1,          8'd0);
    issue(ACT_STORE, 6'd33, 3'd3, 5'd4,  32'd1,          8'd0);

    // Random phases: new count, sometimes a clear, then a few stream fills.
    // Phase 2 runs without any command-side gaps.
    fed   = 0;
    phase = 0;
    while (fed < RANDOM_ITEMS) begin
      case (phase)
        0: setting = 32;
        1: setting = 1;
        2: setting = 24;
        default: begin
          if ($urandom_range(99) < 10)
            setting = ($urandom_range(1) == 0) ? 0 : $urandom_range(33, 63);
          else
            setting = $urandom_range(1, 32);
        end
      endcase
      set_intervals(setting);
      gaps_on = (phase != 2);
      if ($urandom_range(99) < 30) issue_any(ACT_CLEAR);
      repeat ($urandom_range(2, 5)) run_stream();
      phase++;
    end

    // Drain and give the block time to show any stray result.
    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
